@@ src/pude_pkg.sv @@
package pude_pkg;

  localparam int PHASE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ATAN_TAB_LEN        = 24;

  localparam int BIN_W    = 13;
  localparam int FFT_W    = 14;
  localparam int SAMP_W   = 24;
  localparam int DELAY_W  = 32;
  localparam int UNW_W    = 32;
  localparam int SIDX_W   = 26;
  localparam int SSQ_W    = 38;
  localparam int SPH_W    = 44;
  localparam int SIP_W    = 58;
  localparam int MUL_B_W  = 26;
  localparam int FIT_W    = 96;
  localparam int DM_W     = 64;

  typedef enum logic [1:0] {
    REG_BAND_LOW  = 2'd0,
    REG_BAND_HIGH = 2'd1,
    REG_MIN_BINS  = 2'd2,
    REG_FFT_LEN   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_UNWRAP,
    ST_MAC,
    ST_FIT,
    ST_OUT
  } top_state_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_MUL3,
    F_MUL4,
    F_MUL5,
    F_DIV,
    F_DONE
  } fit_state_e;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               valid;
  } fit_res_t;

  // atan(2^-i) in turns, scaled by 2^32
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

@@ src/pude_cordic.sv @@
module pude_cordic import pude_pkg::*; #(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [SAMP_W-1:0]    re_i,
  input  logic signed [SAMP_W-1:0]    im_i,
  output logic                        done_o,
  output logic signed [PHASE_FRAC_BITS:0] phase_o
);

  localparam int NSTEP = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;
  localparam int CW    = $clog2(NSTEP);
  localparam int XW    = SAMP_W + 4;
  localparam int ZW    = PHASE_FRAC_BITS + 3;
  localparam logic signed [ZW-1:0] HALF = {{(ZW-1){1'b0}}, 1'b1} << (PHASE_FRAC_BITS - 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(NSTEP - 1);

  logic                 busy_q, busy_d, done_q, done_d, zero_q, zero_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d, dx, dy, re_x, im_x;
  logic signed [ZW-1:0] z_q, z_d, ang;
  logic [32:0]          rnd;

  assign rnd  = {1'b0, atan_turns(5'(cnt_q))} + (33'd1 << (31 - PHASE_FRAC_BITS));
  assign ang  = ZW'(rnd >> (32 - PHASE_FRAC_BITS));
  assign dx   = y_q >>> cnt_q;
  assign dy   = x_q >>> cnt_q;
  assign re_x = XW'(re_i);
  assign im_x = XW'(im_i);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      zero_d = (re_i == '0) && (im_i == '0);
      // left half plane: pre-rotate by half a turn
      if (re_i < 0) begin
        z_d = (im_i >= 0) ? HALF : -HALF;
        x_d = -re_x;
        y_d = -im_x;
      end else begin
        z_d = '0;
        x_d = re_x;
        y_d = im_x;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + ang;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - ang;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign done_o  = done_q;
  assign phase_o = zero_q ? '0 : z_q[PHASE_FRAC_BITS:0];

endmodule

@@ src/pude_fit.sv @@
module pude_fit import pude_pkg::*; #(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [BIN_W-1:0]  n_i,
  input  logic [SIDX_W-1:0] sx_i,
  input  logic [SSQ_W-1:0]  sxx_i,
  input  logic [SPH_W-1:0]  sy_i,
  input  logic [SIP_W-1:0]  sxy_i,
  input  logic [BIN_W-1:0]  min_bins_i,
  input  logic [FFT_W-1:0]  fft_len_i,
  output logic              done_o,
  output fit_res_t          res_o
);

  localparam int DS = (PHASE_FRAC_BITS > 16) ? PHASE_FRAC_BITS - 16 : 0;
  localparam int NS = (PHASE_FRAC_BITS < 16) ? 16 - PHASE_FRAC_BITS : 0;
  localparam logic [6:0] MUL_LAST = 7'(MUL_B_W - 1);
  localparam logic [6:0] DIV_LAST = 7'(FIT_W - 1);

  fit_state_e state_q, state_d;
  logic signed [FIT_W-1:0] acc_q, acc_d, a_op, den_q, den_d, diff;
  logic [FIT_W-1:0]        t_q, t_d, absden;
  logic [MUL_B_W-1:0]      b_op;
  logic [6:0]              cnt_q, cnt_d;
  logic [DM_W-1:0]         dm_q, dm_d, rem_q, rem_d;
  logic [DM_W:0]           rem2;
  logic                    neg_q, neg_d, ge, bbit, cnt_end;
  fit_res_t                res_q, res_d;

  // operand select for the serial multiplier
  always_comb begin
    case (state_q)
      F_MUL1: begin
        a_op = $signed(FIT_W'(sxx_i));
        b_op = MUL_B_W'(n_i);
      end
      F_MUL2: begin
        a_op = $signed(FIT_W'(sx_i));
        b_op = sx_i;
      end
      F_MUL3: begin
        a_op = FIT_W'($signed(sxy_i));
        b_op = MUL_B_W'(n_i);
      end
      F_MUL4: begin
        a_op = FIT_W'($signed(sy_i));
        b_op = sx_i;
      end
      F_MUL5: begin
        a_op = $signed(t_q);
        b_op = MUL_B_W'(fft_len_i);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign bbit    = b_op[5'(MUL_B_W - 1) - cnt_q[4:0]];
  assign acc_d   = (acc_q <<< 1) + (bbit ? a_op : '0);
  assign diff    = $signed(t_q) - acc_d;
  assign absden  = den_q[FIT_W-1] ? FIT_W'(-den_q) : FIT_W'(den_q);
  assign rem2    = {rem_q, t_q[FIT_W-1]};
  assign ge      = rem2 >= {1'b0, dm_q};
  assign cnt_end = (state_q == F_DIV) ? (cnt_q == DIV_LAST) : (cnt_q == MUL_LAST);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (start_i) state_d = F_MUL1;
      F_MUL1: if (cnt_end) state_d = F_MUL2;
      F_MUL2: begin
        if (cnt_end) begin
          if ((n_i < min_bins_i) || ($signed(t_q) == acc_d)) state_d = F_DONE;
          else state_d = F_MUL3;
        end
      end
      F_MUL3: if (cnt_end) state_d = F_MUL4;
      F_MUL4: if (cnt_end) state_d = F_MUL5;
      F_MUL5: if (cnt_end) state_d = F_DIV;
      F_DIV:  if (cnt_end) state_d = F_DONE;
      F_DONE: state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d = cnt_q;
    t_d   = t_q;
    den_d = den_q;
    dm_d  = dm_q;
    rem_d = rem_q;
    neg_d = neg_q;
    res_d = res_q;
    case (state_q)
      F_IDLE: begin
        cnt_d = '0;
        // result stays put until the next fit starts
        if (start_i) res_d = '0;
      end
      F_MUL1, F_MUL2, F_MUL3, F_MUL4, F_MUL5: begin
        cnt_d = cnt_end ? '0 : cnt_q + 1'b1;
        if (cnt_end) begin
          case (state_q)
            F_MUL1, F_MUL3: t_d = FIT_W'(acc_d);
            F_MUL2: begin
              den_d = diff;
              dm_d  = DM_W'((diff[FIT_W-1] ? FIT_W'(-diff) : FIT_W'(diff)) << DS);
            end
            F_MUL4: begin
              neg_d = diff[FIT_W-1];
              t_d   = diff[FIT_W-1] ? FIT_W'(-diff) : FIT_W'(diff);
            end
            default: begin
              // rounding: add half the divisor before dividing
              t_d   = (FIT_W'(acc_d) << NS) + FIT_W'(dm_q >> 1);
              rem_d = '0;
            end
          endcase
        end
      end
      F_DIV: begin
        cnt_d = cnt_q + 1'b1;
        rem_d = ge ? DM_W'(rem2 - {1'b0, dm_q}) : rem2[DM_W-1:0];
        t_d   = {t_q[FIT_W-2:0], ge};
        if (cnt_end) begin
          res_d.valid = 1'b1;
          if (neg_q == den_q[FIT_W-1]) begin
            if ({t_q[FIT_W-2:0], ge} > FIT_W'(33'h080000000)) res_d.delay = 32'h80000000;
            else res_d.delay = 32'(-{t_q[FIT_W-2:0], ge});
          end else begin
            if ({t_q[FIT_W-2:0], ge} > FIT_W'(32'h7FFFFFFF)) res_d.delay = 32'h7FFFFFFF;
            else res_d.delay = {t_q[30:0], ge};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= (state_q == F_IDLE || cnt_end) ? '0 : acc_d;
    t_q   <= t_d;
    den_q <= den_d;
    dm_q  <= dm_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = (state_q == F_DONE);
  assign res_o  = res_q;

  // absden kept for the divisor check below
  a_dm_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_DIV) |-> (dm_q == DM_W'(absden << DS)))
    else $error("divisor does not match denominator");

endmodule

@@ src/phase_unwrap_delay_estimator_top.sv @@
// Least-squares group delay estimator.
// Slave stream: one frequency-response bin per item, bin 0 first. tdata holds
// resp_re and resp_im, tuser the bin mask, tlast marks the last bin of a spectrum.
// Each bin goes through an iterative CORDIC atan2 (one rotation per cycle),
// phase unwrapping and a multiply-accumulate into the fit sums.
// tready stays low while a bin is being processed. On the last bin the fit
// unit runs up to five bit-serial multiplies and a restoring divide (too few
// bins or a zero denominator ends it early with fit_valid low), then one
// result item is placed in the output register: delay in Q16.16 samples,
// fit_valid in tuser and bins_used. No item is produced for other bins.
// The output register lets the next bin be taken while a result waits; if a
// new result is ready before the old one is taken, the block holds until the
// master side accepts. Configuration is written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must write it only while idle, the block does not
// enforce this. Reset restores the default registers and clears all
// per-spectrum state.
module phase_unwrap_delay_estimator_top import pude_pkg::*; #(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // resp_re, resp_im
  input  logic        s_axis_tuser,   // bin_mask
  input  logic        s_axis_tlast,   // last_bin
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // delay_samples, bins_used, zero pad
  output logic        m_axis_tuser,   // fit_valid
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i
);

  localparam int PW = PHASE_FRAC_BITS + 1;
  localparam logic signed [PW:0] HALF = {{PW{1'b0}}, 1'b1} << (PHASE_FRAC_BITS - 1);
  localparam logic [UNW_W-1:0]   TURN = {{(UNW_W-1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;

  top_state_e state_q, state_d;

  logic [BIN_W-1:0]  band_low_q, band_high_q, min_bins_q;
  logic [FFT_W-1:0]  fft_len_q;

  logic signed [SAMP_W-1:0] re_q, im_q;
  logic              mask_q, last_q;

  logic [BIN_W-1:0]  bin_cnt_q, fit_cnt_q;
  logic [UNW_W-1:0]  unw_q, unw_d;
  logic signed [PW-1:0] prev_q, raw;
  logic              mid_q;
  logic [SIDX_W-1:0] sidx_q, kk_q;
  logic [SSQ_W-1:0]  ssq_q;
  logic [SPH_W-1:0]  sph_q;
  logic [SIP_W-1:0]  sip_q;
  logic signed [PW:0] delta;

  logic signed [UNW_W:0] mul_a;
  logic signed [BIN_W:0] mul_b;
  logic signed [UNW_W+BIN_W+1:0] prod;

  logic              in_acc, in_band, cordic_start, cordic_done, fit_start, fit_done;
  logic              start_q;
  logic              out_load, out_valid_q;
  logic [DELAY_W-1:0] out_delay_q;
  logic              out_fv_q;
  logic [BIN_W-1:0]  out_bins_q;
  fit_res_t          fit_res;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_band = mask_q && (bin_cnt_q >= band_low_q) && (bin_cnt_q <= band_high_q);

  pude_cordic #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cordic_start),
    .re_i   (re_q),
    .im_i   (im_q),
    .done_o (cordic_done),
    .phase_o(raw)
  );

  pude_fit #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_fit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (fit_start),
    .n_i       (fit_cnt_q),
    .sx_i      (sidx_q),
    .sxx_i     (ssq_q),
    .sy_i      (sph_q),
    .sxy_i     (sip_q),
    .min_bins_i(min_bins_q),
    .fft_len_i (fft_len_q),
    .done_o    (fit_done),
    .res_o     (fit_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_CORDIC;
      ST_CORDIC: if (cordic_done) state_d = ST_UNWRAP;
      ST_UNWRAP: state_d = ST_MAC;
      ST_MAC:    state_d = last_q ? ST_FIT : ST_IDLE;
      ST_FIT:    if (fit_done) state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    cordic_start  = start_q;
    fit_start     = (state_q == ST_MAC) && last_q;
    out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  end

  // shared multiplier: k*k in unwrap cycle, phase*k in mac cycle
  assign mul_a = (state_q == ST_UNWRAP) ? $signed({{(UNW_W-BIN_W+1){1'b0}}, bin_cnt_q})
                                        : $signed({unw_q[UNW_W-1], unw_q});
  assign mul_b = $signed({1'b0, bin_cnt_q});
  assign prod  = mul_a * mul_b;

  assign delta = $signed({raw[PW-1], raw}) - $signed({prev_q[PW-1], prev_q});

  always_comb begin
    if (!mid_q) begin
      unw_d = UNW_W'(raw);
    end else begin
      unw_d = unw_q + UNW_W'(delta);
      if (delta > HALF) unw_d = unw_d - TURN;
      else if (delta < -HALF) unw_d = unw_d + TURN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      band_low_q  <= '0;
      band_high_q <= BIN_W'(4096);
      min_bins_q  <= BIN_W'(10);
      fft_len_q   <= FFT_W'(8192);
      bin_cnt_q   <= '0;
      fit_cnt_q   <= '0;
      unw_q       <= '0;
      prev_q      <= '0;
      mid_q       <= 1'b0;
      sidx_q      <= '0;
      ssq_q       <= '0;
      sph_q       <= '0;
      sip_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // cordic starts the cycle after accept, once the item is registered
      start_q <= in_acc;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BAND_LOW:  band_low_q  <= cfg_data_i[BIN_W-1:0];
          REG_BAND_HIGH: band_high_q <= cfg_data_i[BIN_W-1:0];
          REG_MIN_BINS:  min_bins_q  <= cfg_data_i[BIN_W-1:0];
          REG_FFT_LEN:   fft_len_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_UNWRAP) begin
        unw_q  <= unw_d;
        prev_q <= raw;
        mid_q  <= 1'b1;
      end
      if (state_q == ST_MAC) begin
        if (in_band) begin
          sidx_q    <= sidx_q + SIDX_W'(bin_cnt_q);
          ssq_q     <= ssq_q + SSQ_W'(kk_q);
          sph_q     <= sph_q + SPH_W'($signed(unw_q));
          sip_q     <= sip_q + SIP_W'(prod);
          fit_cnt_q <= fit_cnt_q + 1'b1;
        end
        if (!last_q) bin_cnt_q <= bin_cnt_q + 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (out_load) begin
        bin_cnt_q   <= '0;
        fit_cnt_q   <= '0;
        unw_q       <= '0;
        prev_q      <= '0;
        mid_q       <= 1'b0;
        sidx_q      <= '0;
        ssq_q       <= '0;
        sph_q       <= '0;
        sip_q       <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      re_q   <= $signed(s_axis_tdata[23:0]);
      im_q   <= $signed(s_axis_tdata[47:24]);
      mask_q <= s_axis_tuser;
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_UNWRAP) kk_q <= prod[SIDX_W-1:0];
    if (out_load) begin
      out_delay_q <= fit_res.valid ? fit_res.delay : '0;
      out_fv_q    <= fit_res.valid;
      out_bins_q  <= fit_cnt_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_bins_q, out_delay_q};
  assign m_axis_tuser  = out_fv_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CORDIC))
    else $error("accepted item did not start the cordic");

  a_cordic_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> (state_q == ST_CORDIC))
    else $error("cordic finished outside its state");

  a_fit_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_done |-> (state_q == ST_FIT))
    else $error("fit finished outside its state");

  a_clear_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (fit_cnt_q == '0) && (bin_cnt_q == '0) && !mid_q)
    else $error("spectrum state not cleared after result");

endmodule
